/* sv/dhkt_pkg.sv */
// Shared types and constants for the double-hashing key table.
package dhkt_pkg;

    localparam int HASH_W   = 32;
    localparam int SIZE_W   = 10;
    localparam int FILL_W   = 11;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_MIN   = 10'd5;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 10'd1021;

    typedef struct packed {
        logic        mode;
        logic [31:0] key_hash;
        logic [63:0] key_tag;
        logic [15:0] new_value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [9:0]          slot_index;
        logic [15:0]         found_value;
    } t_rsp;

    typedef struct packed {
        logic [SIZE_W-1:0] rem_home;
        logic [SIZE_W-1:0] rem_step;
    } t_mod_res;

endpackage

/* sv/dhkt_mod2.sv */
// Bit-serial unit giving a hash modulo the table size and modulo the size less two.
module dhkt_mod2 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [dhkt_pkg::HASH_W-1:0]   i_hash,
    input  logic [dhkt_pkg::SIZE_W-1:0]   i_size,
    output logic                          o_done,
    output dhkt_pkg::t_mod_res            o_res
);

    logic                          r_run;
    logic [4:0]                    r_cnt;
    logic [dhkt_pkg::HASH_W-1:0]   r_h;
    logic [dhkt_pkg::SIZE_W-1:0]   r_d1;
    logic [dhkt_pkg::SIZE_W-1:0]   r_d2;
    logic [dhkt_pkg::SIZE_W-1:0]   r_r1;
    logic [dhkt_pkg::SIZE_W-1:0]   r_r2;
    logic                          r_done;
    logic [dhkt_pkg::SIZE_W:0]     t1;
    logic [dhkt_pkg::SIZE_W:0]     t2;
    logic [dhkt_pkg::SIZE_W-1:0]   n_r1;
    logic [dhkt_pkg::SIZE_W-1:0]   n_r2;

    // One restoring step per cycle for both divisors, most significant hash bit first.
    always_comb begin
        t1 = {r_r1, r_h[dhkt_pkg::HASH_W-1]};
        t2 = {r_r2, r_h[dhkt_pkg::HASH_W-1]};
        if (t1 >= {1'b0, r_d1}) begin
            n_r1 = dhkt_pkg::SIZE_W'(t1 - {1'b0, r_d1});
        end else begin
            n_r1 = t1[dhkt_pkg::SIZE_W-1:0];
        end
        if (t2 >= {1'b0, r_d2}) begin
            n_r2 = dhkt_pkg::SIZE_W'(t2 - {1'b0, r_d2});
        end else begin
            n_r2 = t2[dhkt_pkg::SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_run <= 1'b1;
                r_cnt <= 5'd31;
                r_h   <= i_hash;
                r_d1  <= i_size;
                r_d2  <= i_size - dhkt_pkg::SIZE_W'(2);
                r_r1  <= '0;
                r_r2  <= '0;
            end else if (r_run) begin
                r_r1 <= n_r1;
                r_r2 <= n_r2;
                r_h  <= {r_h[dhkt_pkg::HASH_W-2:0], 1'b0};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done       = r_done;
    assign o_res.rem_home = r_r1;
    assign o_res.rem_step = r_r2;

endmodule

/* sv/double_hash_key_table_top.sv */
// Top level of the double-hashing key table: control, slot memory and fill count.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+--------------------------------
//  request   | start / busy          | i_req  (mode, hash, key, value)
//  result    | o_valid (one cycle)   | o_rsp  (status, slot, value)
//  config    | i_cfg_we              | i_cfg_wdata (table_size)
//
// A word first has its two remainders worked out bit by bit in the shared
// modulo unit, then each slot probed takes a read and a check state through
// the registered-read slot memory; the result strobes in the cycle after the
// last check. After reset the slot memory is swept clear with busy high.
// Results cannot be stalled; a new word is taken once busy falls.
module double_hash_key_table_top #(
    parameter int SLOTS      = 1024,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  dhkt_pkg::t_req              i_req,
    output logic                        o_valid,
    output dhkt_pkg::t_rsp              o_rsp,
    input  logic                        i_cfg_we,
    input  logic [dhkt_pkg::SIZE_W-1:0] i_cfg_wdata
);

    localparam int AW      = $clog2(SLOTS);
    localparam int ENTRY_W = dhkt_pkg::HASH_W + KEY_BITS + VALUE_BITS;
    localparam int MAXS    = (SLOTS - 1 > 1023) ? 1023 : SLOTS - 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;

    typedef struct packed {
        logic [dhkt_pkg::HASH_W-1:0] hash;
        logic [KEY_BITS-1:0]         key;
        logic [VALUE_BITS-1:0]       value;
    } t_entry;

    t_entry                          mem [SLOTS];
    t_entry                          r_rdata;

    logic [2:0]                      r_state;
    logic [AW-1:0]                   r_clr;
    logic [dhkt_pkg::SIZE_W-1:0]     r_table_size;
    logic [dhkt_pkg::SIZE_W-1:0]     r_size;
    logic [dhkt_pkg::FILL_W-1:0]     r_fill;
    logic                            r_mode;
    logic [dhkt_pkg::HASH_W-1:0]     r_hash;
    logic [KEY_BITS-1:0]             r_key;
    logic [VALUE_BITS-1:0]           r_val;
    logic [dhkt_pkg::SIZE_W-1:0]     r_idx;
    logic [dhkt_pkg::SIZE_W-1:0]     r_first;
    logic [dhkt_pkg::SIZE_W-1:0]     r_step;
    logic                            r_valid;
    dhkt_pkg::t_rsp                  r_rsp;

    logic [dhkt_pkg::SIZE_W-1:0]     eff_size;
    logic                            mod_go;
    logic                            mod_done;
    dhkt_pkg::t_mod_res              mod_res;
    logic                            occ;
    logic                            hit;
    logic [dhkt_pkg::SIZE_W-1:0]     n_idx;
    logic                            mem_we;
    logic [AW-1:0]                   mem_wa;
    t_entry                          mem_wd;

    always_comb begin
        if (r_table_size < dhkt_pkg::SIZE_MIN) begin
            eff_size = dhkt_pkg::SIZE_MIN;
        end else if (r_table_size > dhkt_pkg::SIZE_W'(MAXS)) begin
            eff_size = dhkt_pkg::SIZE_W'(MAXS);
        end else begin
            eff_size = r_table_size;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign mod_go = start && !busy;

    dhkt_mod2 u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (mod_go),
        .i_hash  ((i_req.key_hash == '0) ? dhkt_pkg::HASH_W'(1) : i_req.key_hash),
        .i_size  (eff_size),
        .o_done  (mod_done),
        .o_res   (mod_res)
    );

    assign occ = (r_rdata.hash != '0);
    assign hit = (r_rdata.hash == r_hash) && (r_rdata.key == r_key);

    // Step back with wrap-around inside slots 1..size.
    always_comb begin
        if (r_idx <= r_step) begin
            n_idx = r_size + r_idx - r_step;
        end else begin
            n_idx = r_idx - r_step;
        end
    end

    // Write port: the clearing sweep, or the single write-back that ends a successful insert.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = AW'(r_idx);
        mem_wd = r_rdata;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
            mem_wd = '0;
        end else if (r_state == S_CHK && r_mode) begin
            if (hit) begin
                mem_we       = 1'b1;
                mem_wd.value = r_val;
            end else if (!occ && (r_fill < {1'b0, r_size})) begin
                mem_we = 1'b1;
                mem_wd = '{hash: r_hash, key: r_key, value: r_val};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[AW'(r_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_table_size <= dhkt_pkg::SIZE_RESET;
            r_fill       <= '0;
            r_valid      <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_table_size <= i_cfg_wdata;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_mode  <= i_req.mode;
                        r_hash  <= (i_req.key_hash == '0) ? dhkt_pkg::HASH_W'(1)
                                                          : i_req.key_hash;
                        r_key   <= KEY_BITS'(i_req.key_tag);
                        r_val   <= VALUE_BITS'(i_req.new_value);
                        r_size  <= eff_size;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (mod_done) begin
                        r_idx   <= mod_res.rem_home + dhkt_pkg::SIZE_W'(1);
                        r_first <= mod_res.rem_home + dhkt_pkg::SIZE_W'(1);
                        r_step  <= mod_res.rem_step + dhkt_pkg::SIZE_W'(1);
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_rsp.slot_index  <= r_idx;
                    r_rsp.found_value <= '0;
                    if (hit) begin
                        r_valid      <= 1'b1;
                        r_rsp.status <= dhkt_pkg::ST_OK;
                        if (!r_mode) begin
                            r_rsp.found_value <= 16'(r_rdata.value);
                        end
                        r_state <= S_IDLE;
                    end else if (!occ) begin
                        r_valid <= 1'b1;
                        if (!r_mode) begin
                            r_rsp.status <= dhkt_pkg::ST_MISS;
                        end else if (r_fill < {1'b0, r_size}) begin
                            r_rsp.status <= dhkt_pkg::ST_OK;
                            r_fill       <= r_fill + dhkt_pkg::FILL_W'(1);
                        end else begin
                            r_rsp.status <= dhkt_pkg::ST_FULL;
                        end
                        r_state <= S_IDLE;
                    end else if (n_idx == r_first) begin
                        // Probe came back to the home slot, which is occupied.
                        r_valid          <= 1'b1;
                        r_rsp.slot_index <= n_idx;
                        r_rsp.status     <= r_mode ? dhkt_pkg::ST_FULL : dhkt_pkg::ST_MISS;
                        r_state          <= S_IDLE;
                    end else begin
                        r_idx   <= n_idx;
                        r_state <= S_PROBE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    a_valid_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == S_CHK)
        else $error("result strobe without a finished probe");

    a_start_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.status == dhkt_pkg::ST_OK || o_rsp.status == dhkt_pkg::ST_MISS
                     || o_rsp.status == dhkt_pkg::ST_FULL))
        else $error("illegal status code");

    a_fill_grows_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != $past(r_fill)) |-> (r_fill == $past(r_fill) + dhkt_pkg::FILL_W'(1)
                                       && o_valid && o_rsp.status == dhkt_pkg::ST_OK))
        else $error("fill count moved without a successful insert");

endmodule
